[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Next-cycle implication that is also checked during reset.
`define AFC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle implication failed during reset");

`endif

[design/afc_pkg.sv]
// ----------------------------------------------------------------------------
// afc_pkg
// Constants, field layout and codes for the box frustum culling block.
// ----------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

    // Number of plane slots in the frustum store (1 to 8).
    localparam int PLANE_COUNT = 6;

    // Field widths.
    localparam int INDEX_W = 3;
    localparam int NORM_W  = 16;
    localparam int OFFS_W  = 32;
    localparam int COORD_W = 32;
    localparam int HALF_W  = 31;

    // Intermediate widths: every sum stays exact.
    localparam int RPROD_W = HALF_W + NORM_W;        // half * |normal|
    localparam int DPROD_W = COORD_W + NORM_W;       // normal * center
    localparam int RSUM_W  = RPROD_W + 2;            // three unsigned terms
    localparam int DSUM_W  = DPROD_W + 2;            // three signed terms
    localparam int CMP_W   = DSUM_W + 1;             // d + r, distance
    localparam int FRAC_SHIFT = 14;                  // Q16.16 to Q18.30

    // Input tdata layout, lowest bit first.
    localparam int IN_TDATA_W = 272;
    localparam int OFF_INDEX  = 0;
    localparam int OFF_NX     = OFF_INDEX + INDEX_W;
    localparam int OFF_NY     = OFF_NX + NORM_W;
    localparam int OFF_NZ     = OFF_NY + NORM_W;
    localparam int OFF_DIST   = OFF_NZ + NORM_W;
    localparam int OFF_CX     = OFF_DIST + OFFS_W;
    localparam int OFF_CY     = OFF_CX + COORD_W;
    localparam int OFF_CZ     = OFF_CY + COORD_W;
    localparam int OFF_HX     = OFF_CZ + COORD_W;
    localparam int OFF_HY     = OFF_HX + HALF_W;
    localparam int OFF_HZ     = OFF_HY + HALF_W;

    // Output tdata: the visible flag in bit 0, zero padded to a byte.
    localparam int OUT_TDATA_W = 8;

    // Command codes carried in tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

endpackage

`default_nettype wire

[design/aabb_frustum_cull.sv]
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Culls axis-aligned boxes against a six-plane frustum held in registers.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                                     tuser
//  s_axis    in         index, normal x/y/z, offset, center x/y/z,  command
//                       half x/y/z (272 bits)
//  m_axis    out        visible in bit 0, zero padded to 8 bits   -
//
//  One word is accepted per cycle while no stage is stalled; a box result
//  passes from the input stage through the four register stages behind it
//  (products, sums, plane compare, output). A load word writes its plane
//  slot as it leaves the input stage and makes no result.
//  Reset clears the valid bits and the plane store to all-zero planes.
//  Each stage holds while the stage after it is full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_frustum_cull (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Command stream.
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: plane_index, normal_x, normal_y, normal_z, plane_offset,
    //        center_x, center_y, center_z, half_x, half_y, half_z
    input  wire logic [afc_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: command
    input  wire logic                           i_s_axis_tuser,
    // Result stream.
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata: visible, then zero padding
    output logic [afc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    import afc_pkg::*;

    // Stage advance enables, from the output back to the input.
    logic adv_s1, adv_s2, adv_s3, adv_s4, adv_out;

    // Input stage.
    logic                      r_s1_valid;
    logic                      r_s1_cmd;
    logic [INDEX_W-1:0]        r_s1_index;
    logic signed [NORM_W-1:0]  r_s1_norm [3];
    logic signed [OFFS_W-1:0]  r_s1_dist;
    logic signed [COORD_W-1:0] r_s1_center [3];
    logic [HALF_W-1:0]         r_s1_half [3];

    // Plane store: normal, its magnitude and the distance.
    logic signed [NORM_W-1:0]  r_pl_norm [PLANE_COUNT][3];
    logic [NORM_W-1:0]         r_pl_mag  [PLANE_COUNT][3];
    logic signed [OFFS_W-1:0]  r_pl_dist [PLANE_COUNT];
    logic [NORM_W-1:0]         n_mag [3];

    // Product stage.
    logic                      r_s2_valid;
    logic [RPROD_W-1:0]        r_s2_rprod [PLANE_COUNT][3];
    logic signed [DPROD_W-1:0] r_s2_dprod [PLANE_COUNT][3];
    logic signed [OFFS_W-1:0]  r_s2_dist  [PLANE_COUNT];

    // Sum stage.
    logic                      r_s3_valid;
    logic [RSUM_W-1:0]         r_s3_rsum [PLANE_COUNT];
    logic signed [DSUM_W-1:0]  r_s3_dsum [PLANE_COUNT];
    logic signed [OFFS_W-1:0]  r_s3_dist [PLANE_COUNT];

    // Compare stage.
    logic                      r_s4_valid;
    logic [PLANE_COUNT-1:0]    r_s4_cull;
    logic [PLANE_COUNT-1:0]    n_cull;

    // Output register.
    logic                      r_out_valid;
    logic                      r_out_visible;

    // A stage moves when it is empty or the next stage moves.
    assign adv_out = !r_out_valid || i_m_axis_tready;
    assign adv_s4  = !r_s4_valid || adv_out;
    assign adv_s3  = !r_s3_valid || adv_s4;
    assign adv_s2  = !r_s2_valid || adv_s3;
    assign adv_s1  = !r_s1_valid || adv_s2;

    assign o_s_axis_tready = adv_s1;

    // Input stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv_s1) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    // Input stage payload: unpack the word.
    always_ff @(posedge i_clk) begin
        if (adv_s1) begin
            r_s1_cmd       <= i_s_axis_tuser;
            r_s1_index     <= i_s_axis_tdata[OFF_INDEX +: INDEX_W];
            r_s1_norm[0]   <= $signed(i_s_axis_tdata[OFF_NX +: NORM_W]);
            r_s1_norm[1]   <= $signed(i_s_axis_tdata[OFF_NY +: NORM_W]);
            r_s1_norm[2]   <= $signed(i_s_axis_tdata[OFF_NZ +: NORM_W]);
            r_s1_dist      <= $signed(i_s_axis_tdata[OFF_DIST +: OFFS_W]);
            r_s1_center[0] <= $signed(i_s_axis_tdata[OFF_CX +: COORD_W]);
            r_s1_center[1] <= $signed(i_s_axis_tdata[OFF_CY +: COORD_W]);
            r_s1_center[2] <= $signed(i_s_axis_tdata[OFF_CZ +: COORD_W]);
            r_s1_half[0]   <= i_s_axis_tdata[OFF_HX +: HALF_W];
            r_s1_half[1]   <= i_s_axis_tdata[OFF_HY +: HALF_W];
            r_s1_half[2]   <= i_s_axis_tdata[OFF_HZ +: HALF_W];
        end
    end

    // Magnitude of each normal component; the most negative code maps to 2^15.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = r_s1_norm[i][NORM_W-1] ? NORM_W'(-r_s1_norm[i])
                                              : NORM_W'(r_s1_norm[i]);
        end
    end

    // Plane store write as a load leaves the input stage, in stream order.
    // A slot number beyond the store matches no entry and is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                for (int i = 0; i < 3; i++) begin
                    r_pl_norm[p][i] <= '0;
                    r_pl_mag[p][i]  <= '0;
                end
                r_pl_dist[p] <= '0;
            end
        end else if (r_s1_valid && adv_s2 && r_s1_cmd == CMD_LOAD) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                if (32'(r_s1_index) == p) begin
                    for (int i = 0; i < 3; i++) begin
                        r_pl_norm[p][i] <= r_s1_norm[i];
                        r_pl_mag[p][i]  <= n_mag[i];
                    end
                    r_pl_dist[p] <= r_s1_dist;
                end
            end
        end
    end

    // Only box tests travel past the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv_s2) begin
            r_s2_valid <= r_s1_valid && r_s1_cmd == CMD_TEST;
        end
    end

    // Product stage: one multiplier per plane and axis for each term.
    always_ff @(posedge i_clk) begin
        if (adv_s2) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                for (int i = 0; i < 3; i++) begin
                    r_s2_rprod[p][i] <= RPROD_W'(r_s1_half[i]) * RPROD_W'(r_pl_mag[p][i]);
                    r_s2_dprod[p][i] <= DPROD_W'(r_pl_norm[p][i]) * DPROD_W'(r_s1_center[i]);
                end
                r_s2_dist[p] <= r_pl_dist[p];
            end
        end
    end

    // Sum stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv_s3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    // Sum stage: projected radius and center dot product per plane.
    always_ff @(posedge i_clk) begin
        if (adv_s3) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_s3_rsum[p] <= RSUM_W'(r_s2_rprod[p][0]) + RSUM_W'(r_s2_rprod[p][1])
                              + RSUM_W'(r_s2_rprod[p][2]);
                r_s3_dsum[p] <= DSUM_W'(r_s2_dprod[p][0]) + DSUM_W'(r_s2_dprod[p][1])
                              + DSUM_W'(r_s2_dprod[p][2]);
                r_s3_dist[p] <= r_s2_dist[p];
            end
        end
    end

    // A plane culls the box when dot plus radius falls below its distance.
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            n_cull[p] = (CMP_W'(r_s3_dsum[p]) + CMP_W'($signed({1'b0, r_s3_rsum[p]})))
                      < CMP_W'($signed({r_s3_dist[p], FRAC_SHIFT'(0)}));
        end
    end

    // Compare stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (adv_s4) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s4) begin
            r_s4_cull <= n_cull;
        end
    end

    // Output register: visible unless some plane culls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_out_visible <= !(|r_s4_cull);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W-1)'(0), r_out_visible};

endmodule

`default_nettype wire

[design/afc_checker.sv]
// ----------------------------------------------------------------------------
// afc_checker
// Port-level assertions for the box frustum culling block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module afc_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            o_s_axis_tready,
    input  wire logic                            o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    input  wire logic [afc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    import afc_pkg::*;

    // A result word waiting on the sink keeps its value.
    `AFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // Only the visible flag is ever set in a result word.
    `AFC_ASSERT_IMPL(a_out_pad, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[OUT_TDATA_W-1:1] == '0)

    // With the output register empty, no stage can block the input.
    `AFC_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)

    // Reset empties the output register.
    `AFC_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

[dv/afc_cull_checker.sv]
// ----------------------------------------------------------------------------
// afc_cull_checker
// Watches both streams of the box culling block. It keeps its own copy of the
// plane store, predicts the visible flag of every box word it sees accepted,
// and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module afc_cull_checker
    import afc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_s_tuser,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                          o_fail_count,
    output int                          o_pending
);

    // Shadow plane store, cleared by reset like the block's own.
    logic signed [NORM_W-1:0] plane_nx [PLANE_COUNT];
    logic signed [NORM_W-1:0] plane_ny [PLANE_COUNT];
    logic signed [NORM_W-1:0] plane_nz [PLANE_COUNT];
    logic signed [OFFS_W-1:0] plane_dist [PLANE_COUNT];

    // Visible flags still owed by the block, oldest first.
    logic visible_due [$];
    int   mismatches = 0;
    int   owed = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = owed;

    // Magnitude of a sign-extended normal component.
    function automatic longint norm_mag(input longint n);
        return (n < 0) ? -n : n;
    endfunction

    // A box survives unless center dot normal plus projected radius falls
    // below the plane distance for some plane. All terms in Q18.30.
    function automatic logic box_visible(input logic [IN_TDATA_W-1:0] w);
        longint cx, cy, cz, hx, hy, hz;
        longint nx, ny, nz;
        longint reach, dot, bound;
        logic   vis;
        cx  = longint'($signed(w[OFF_CX +: COORD_W]));
        cy  = longint'($signed(w[OFF_CY +: COORD_W]));
        cz  = longint'($signed(w[OFF_CZ +: COORD_W]));
        hx  = longint'(w[OFF_HX +: HALF_W]);
        hy  = longint'(w[OFF_HY +: HALF_W]);
        hz  = longint'(w[OFF_HZ +: HALF_W]);
        vis = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            nx    = longint'(plane_nx[p]);
            ny    = longint'(plane_ny[p]);
            nz    = longint'(plane_nz[p]);
            reach = hx * norm_mag(nx) + hy * norm_mag(ny) + hz * norm_mag(nz);
            dot   = nx * cx + ny * cy + nz * cz;
            bound = longint'(plane_dist[p]) <<< FRAC_SHIFT;
            if (dot + reach < bound) begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    // Results are checked before the input word of the same edge is taken
    // in; a result can never belong to a word accepted at the same edge.
    always @(posedge i_clk) begin : track
        logic want;
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                plane_nx[p]   = '0;
                plane_ny[p]   = '0;
                plane_nz[p]   = '0;
                plane_dist[p] = '0;
            end
            visible_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (visible_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with none expected: expected none, got visible=%0b",
                             $time, i_m_tdata[0]);
                end else begin
                    want = visible_due.pop_front();
                    if (i_m_tdata[0] !== want) begin
                        mismatches++;
                        $display("%0t: visible mismatch: expected %0b, got %0b",
                                 $time, want, i_m_tdata[0]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == CMD_TEST) begin
                    visible_due.push_back(box_visible(i_s_tdata));
                end else if (i_s_tdata[OFF_INDEX +: INDEX_W] < PLANE_COUNT) begin
                    // Loads beyond the last slot leave the store alone.
                    plane_nx[i_s_tdata[OFF_INDEX +: INDEX_W]]   = i_s_tdata[OFF_NX +: NORM_W];
                    plane_ny[i_s_tdata[OFF_INDEX +: INDEX_W]]   = i_s_tdata[OFF_NY +: NORM_W];
                    plane_nz[i_s_tdata[OFF_INDEX +: INDEX_W]]   = i_s_tdata[OFF_NZ +: NORM_W];
                    plane_dist[i_s_tdata[OFF_INDEX +: INDEX_W]] = i_s_tdata[OFF_DIST +: OFFS_W];
                end
            end
        end
        owed = visible_due.size();
    end

endmodule

[dv/aabb_frustum_cull_test.sv]
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test
// Drives plane loads and box tests into the culling block: a directed set of
// boundary and extreme cases, then bursts of plane loads followed by box
// tests, at frustum scale and at full range. Both stream sides idle at
// random but in the last phase. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test;
    import afc_pkg::*;

    localparam int ITEMS_PER_PHASE = 650;
    localparam int DRAIN_CYCLES    = 20;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = CMD_LOAD;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;

    int src_idle_pct  = 33;
    int sink_idle_pct = 65;
    int fail_count;
    int pending_count;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    aabb_frustum_cull i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    afc_cull_checker u_cull_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Result side backpressure.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("aabb_frustum_cull_test failed");
        $finish;
    end

    // Random fill for the fields a word's command does not use.
    function automatic logic [IN_TDATA_W-1:0] junk_word();
        logic [IN_TDATA_W-1:0] w;
        for (int k = 0; k < IN_TDATA_W; k += 16) begin
            w[k +: 16] = 16'($urandom);
        end
        return w;
    endfunction

    // Q16.16 value: near the origin for frustum-scale bursts, else any value
    // with the extremes favored.
    function automatic logic [31:0] pick_coord(input logic wide);
        if (!wide) begin
            return 32'($urandom_range(0, 128 << 16)) - 32'(64 << 16);
        end
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Q2.14 normal component.
    function automatic logic [15:0] pick_normal(input logic wide);
        if (!wide) begin
            return 16'($urandom_range(0, 32768)) - 16'd16384;
        end
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Q16.16 half extent, never negative.
    function automatic logic [30:0] pick_half(input logic wide);
        if (!wide) begin
            return 31'($urandom_range(0, 16 << 16));
        end
        case ($urandom_range(3))
            0:       return 31'h0;
            1:       return 31'h7FFF_FFFF;
            default: return 31'($urandom);
        endcase
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic push_word(input logic cmd, input logic [IN_TDATA_W-1:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic load_plane(input logic [2:0] idx, input logic [15:0] nx,
                              input logic [15:0] ny, input logic [15:0] nz,
                              input logic [31:0] offs);
        logic [IN_TDATA_W-1:0] w;
        w = junk_word();
        w[OFF_INDEX +: INDEX_W] = idx;
        w[OFF_NX +: NORM_W]     = nx;
        w[OFF_NY +: NORM_W]     = ny;
        w[OFF_NZ +: NORM_W]     = nz;
        w[OFF_DIST +: OFFS_W]   = offs;
        push_word(CMD_LOAD, w);
    endtask

    task automatic test_box(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [30:0] hx,
                            input logic [30:0] hy, input logic [30:0] hz);
        logic [IN_TDATA_W-1:0] w;
        w = junk_word();
        w[OFF_CX +: COORD_W] = cx;
        w[OFF_CY +: COORD_W] = cy;
        w[OFF_CZ +: COORD_W] = cz;
        w[OFF_HX +: HALF_W]  = hx;
        w[OFF_HY +: HALF_W]  = hy;
        w[OFF_HZ +: HALF_W]  = hz;
        push_word(CMD_TEST, w);
    endtask

    // A few plane loads, some cleared, some aimed past the store, then a
    // run of box tests at the same scale.
    task automatic cull_burst(inout int count);
        logic wide;
        int   loads;
        int   boxes;
        logic [2:0] idx;
        wide  = ($urandom_range(3) == 0);
        loads = $urandom_range(1, 6);
        boxes = $urandom_range(4, 30);
        for (int k = 0; k < loads; k++) begin
            idx = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(PLANE_COUNT - 1));
            if ($urandom_range(3) == 0) begin
                load_plane(idx, '0, '0, '0, '0);
            end else begin
                load_plane(idx, pick_normal(wide), pick_normal(wide), pick_normal(wide),
                           pick_coord(wide));
            end
        end
        for (int k = 0; k < boxes; k++) begin
            test_box(pick_coord(wide), pick_coord(wide), pick_coord(wide),
                     pick_half(wide), pick_half(wide), pick_half(wide));
        end
        count += loads + boxes;
    endtask

    initial begin : stimulus
        int count;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Never-loaded store: every box is visible.
        test_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 31'h7FFF_FFFF, 31'h0, 31'h7FFF_FFFF);
        // Plane x >= 1.0; the exact-touch cases stay visible.
        load_plane(3'd0, 16'd16384, 16'd0, 16'd0, ONE_Q16);
        test_box(ONE_Q16, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0);
        test_box(ONE_Q16 - 1, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0);
        test_box(32'h0, 32'h0, 32'h0, 31'(ONE_Q16), 31'h0, 31'h0);
        test_box(32'h0, 32'h0, 32'h0, 31'(ONE_Q16 - 1), 31'h0, 31'h0);
        // Loads past the store must change nothing.
        load_plane(3'd6, 16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF);
        load_plane(3'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF);
        test_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0, 31'h0, 31'h0);
        // Most negative normals and distance.
        load_plane(3'd5, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000);
        test_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0, 31'h0, 31'h0);
        test_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        // Most positive normals and distance.
        load_plane(3'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF);
        test_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        test_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        load_plane(3'd2, 16'hC000, 16'h4000, 16'h0000, 32'hFFFF_0000);
        load_plane(3'd3, 16'h0000, 16'hC000, 16'h4000, 32'h0000_8000);
        load_plane(3'd4, 16'h4000, 16'h0000, 16'hC000, 32'hFFFF_8000);
        test_box(32'h0, 32'h0, 32'h0, 31'(ONE_Q16), 31'(ONE_Q16), 31'(ONE_Q16));
        test_box(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 31'h1, 31'h1, 31'h1);
        // Clear the whole store again: everything visible.
        for (int k = 0; k < PLANE_COUNT; k++) begin
            load_plane(3'(k), '0, '0, '0, '0);
        end
        test_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 31'h0, 31'h0);

        // Random bursts under three idling patterns.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 33;
                    sink_idle_pct = 65;
                end
                1: begin
                    src_idle_pct  = 65;
                    sink_idle_pct = 33;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            count = 0;
            while (count < ITEMS_PER_PHASE) cull_burst(count);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for any stray result word.
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("aabb_frustum_cull_test passed");
        end else begin
            $display("aabb_frustum_cull_test failed");
        end
        $finish;
    end

endmodule
